>>> rtl/brf_pkg.sv
// ============================================================================
// brf_pkg: shared types for the byte ring FIFO
// Command codes, transfer structs and default geometry.
// ============================================================================
`default_nettype none

package brf_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int FIELD_W       = 10;

    typedef enum logic [2:0] {
        CMD_PUSH      = 3'd0,
        CMD_POP       = 3'd1,
        CMD_PEEK      = 3'd2,
        CMD_ADV_REAR  = 3'd3,
        CMD_ADV_FRONT = 3'd4,
        CMD_CLEAR     = 3'd5,
        CMD_STATUS    = 3'd6
    } cmd_t;

    typedef struct packed {
        cmd_t                 command;
        logic [7:0]           data_byte;
        logic [FIELD_W-1:0]   count;
        logic                 request_last;
    } brf_in_t;

    typedef struct packed {
        logic                 ok;
        logic [7:0]           read_byte;
        logic [FIELD_W-1:0]   used_count;
        logic [FIELD_W-1:0]   free_count;
        logic [FIELD_W-1:0]   direct_write_room;
        logic [FIELD_W-1:0]   direct_read_room;
        logic [FIELD_W-1:0]   front_position;
        logic [FIELD_W-1:0]   rear_position;
        logic                 last;
    } brf_out_t;

endpackage

`default_nettype wire

>>> rtl/brf_ram.sv
// ============================================================================
// brf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
`default_nettype none

module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/byte_ring_fifo_unit.sv
// ============================================================================
// byte_ring_fifo_unit: circular byte FIFO with one slot kept empty
// Executes one command per transfer and reports the FIFO geometry.
// ============================================================================
// Usage:
//   Command channel: drive item and raise start; a transfer happens at every
//   rising edge with start high and busy low. busy stays low, so a command
//   can be issued in every cycle (throughput one item per clock).
//   Result channel: result_valid is high for exactly one cycle, in the cycle
//   after the command transfer. The receiver cannot stall.
//   The result is registered to line up with the registered read port of the
//   byte store; pointer update and geometry are settled in the command cycle.
//   The FIFO holds at most DEPTH-1 bytes. Push, pop and peek are refused
//   (ok low) when full, empty, or the offset is past the used count.
//   Advance commands move a pointer by count modulo DEPTH with no check;
//   a zero step is refused. Clear zeroes both pointers and keeps the data.
//   Counts and pointers in the result are the low 10 bits.
//   Reset: both pointers go to zero and no result is pending. The byte
//   store is not cleared; a read of a never-written slot returns garbage.
// ============================================================================
`default_nettype none

module byte_ring_fifo_unit #(
    parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire brf_pkg::brf_in_t item,
    output logic                  result_valid,
    output brf_pkg::brf_out_t     result
);

    import brf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int PW = ((AW > FIELD_W) ? AW : FIELD_W) + 1;
    // Conditional subtract steps that bring a count below DEPTH
    localparam int RED_STEPS = $clog2((1024 + DEPTH - 1) / DEPTH);

    logic [AW-1:0]      front_reg, front_next;
    logic [AW-1:0]      rear_reg, rear_next;
    logic               result_valid_reg;
    logic               rd_ok_reg, rd_ok_next;
    brf_out_t           res_reg, res_next;

    logic [FIELD_W-1:0] cnt_red;
    logic [PW-1:0]      used_now, free_now;
    logic [AW-1:0]      peek_addr;
    logic [AW-1:0]      rd_addr;
    logic               push_ok, pop_ok, peek_ok;
    logic               cmd_ok;
    logic               wr_en, rd_en;
    logic [7:0]         rd_data;

    // Add a step to a pointer and wrap modulo DEPTH; step is below DEPTH
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [PW-1:0] step);
        logic [PW-1:0] sum;
        sum = PW'(base) + step;
        if (sum >= PW'(DEPTH))
        begin
            sum = sum - PW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [PW-1:0] used_of(input logic [AW-1:0] f,
                                              input logic [AW-1:0] r);
        if (r >= f)
        begin
            return PW'(r) - PW'(f);
        end
        return PW'(DEPTH) - PW'(f) + PW'(r);
    endfunction

    // Reduce the 10-bit count modulo DEPTH by restoring subtraction
    always_comb
    begin
        cnt_red = item.count;
        for (int k = RED_STEPS - 1; k >= 0; k--)
        begin
            if (int'(cnt_red) >= (DEPTH << k))
            begin
                cnt_red = cnt_red - FIELD_W'(DEPTH << k);
            end
        end
    end

    assign used_now  = used_of(front_reg, rear_reg);
    assign free_now  = PW'(DEPTH - 1) - used_now;
    assign push_ok   = (free_now != '0);
    assign pop_ok    = (used_now != '0);
    assign peek_ok   = (PW'(item.count) < used_now);
    assign peek_addr = wrap_add(front_reg, PW'(cnt_red));

    // Command decode: pointer update and store access
    always_comb
    begin
        cmd_ok     = 1'b0;
        front_next = front_reg;
        rear_next  = rear_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = front_reg;
        if (start)
        begin
            case (item.command)
                CMD_PUSH:
                begin
                    if (push_ok)
                    begin
                        wr_en     = 1'b1;
                        rear_next = wrap_add(rear_reg, PW'(1));
                        cmd_ok    = 1'b1;
                    end
                end
                CMD_POP:
                begin
                    if (pop_ok)
                    begin
                        rd_en      = 1'b1;
                        front_next = wrap_add(front_reg, PW'(1));
                        cmd_ok     = 1'b1;
                    end
                end
                CMD_PEEK:
                begin
                    if (peek_ok)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = peek_addr;
                        cmd_ok  = 1'b1;
                    end
                end
                CMD_ADV_REAR:
                begin
                    if (item.count != '0)
                    begin
                        rear_next = wrap_add(rear_reg, PW'(cnt_red));
                        cmd_ok    = 1'b1;
                    end
                end
                CMD_ADV_FRONT:
                begin
                    if (item.count != '0)
                    begin
                        front_next = wrap_add(front_reg, PW'(cnt_red));
                        cmd_ok     = 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    front_next = '0;
                    rear_next  = '0;
                    cmd_ok     = 1'b1;
                end
                CMD_STATUS:
                begin
                    cmd_ok = 1'b1;
                end
                default:
                begin
                    cmd_ok = 1'b0;
                end
            endcase
        end
        rd_ok_next = rd_en;
    end

    // Geometry after the command, taken from the next pointer values
    always_comb
    begin
        logic [PW-1:0] used_n, wroom, rroom;
        used_n = used_of(front_next, rear_next);
        if (rear_next >= front_next)
        begin
            wroom = (front_next == '0) ? PW'(DEPTH - 1) - PW'(rear_next)
                                       : PW'(DEPTH) - PW'(rear_next);
            rroom = PW'(rear_next) - PW'(front_next);
        end
        else
        begin
            wroom = PW'(front_next) - PW'(rear_next) - PW'(1);
            rroom = PW'(DEPTH) - PW'(front_next);
        end
        res_next.ok                = cmd_ok;
        res_next.read_byte         = '0;
        res_next.last              = item.request_last;
        res_next.used_count        = used_n[FIELD_W-1:0];
        res_next.free_count        = 10'(PW'(DEPTH - 1) - used_n);
        res_next.direct_write_room = wroom[FIELD_W-1:0];
        res_next.direct_read_room  = rroom[FIELD_W-1:0];
        res_next.front_position    = 10'(PW'(front_next));
        res_next.rear_position     = 10'(PW'(rear_next));
    end

    brf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (rear_reg),
        .wr_data (item.data_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Control state: pointers and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg        <= '0;
            rear_reg         <= '0;
            result_valid_reg <= 1'b0;
            rd_ok_reg        <= 1'b0;
        end
        else
        begin
            front_reg        <= front_next;
            rear_reg         <= rear_next;
            result_valid_reg <= start;
            rd_ok_reg        <= rd_ok_next;
        end
    end

    // Result payload: load on every transfer, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            res_reg <= res_next;
        end
    end

    // Merge the registered store output into the result
    always_comb
    begin
        result           = res_reg;
        result.read_byte = rd_ok_reg ? rd_data : 8'd0;
    end

    assign result_valid = result_valid_reg;
    assign busy         = 1'b0;

    // Every transfer yields one result strobe in the next cycle
    a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> result_valid)
        else $error("result strobe missing after command transfer");

    // Pointers stay inside the ring
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (PW'(front_reg) < PW'(DEPTH)) && (PW'(rear_reg) < PW'(DEPTH)))
        else $error("pointer outside ring");

    // Clear zeroes both pointers
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (start && item.command == CMD_CLEAR) |=> (front_reg == '0 && rear_reg == '0))
        else $error("clear did not reset pointers");

    // A refused push leaves the rear pointer alone
    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (start && item.command == CMD_PUSH && !push_ok) |=> $stable(rear_reg))
        else $error("rear moved on refused push");

    // A store read is returned only for a strobed result
    a_read_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        rd_ok_reg |-> (result_valid && result.ok))
        else $error("store read without accepted result");

endmodule

`default_nettype wire
